// ----- rtl/core/edps_pkg.sv -----
// shared types, constants and helpers for the edit distance prefix score unit
// used by every module of the block; depends on nothing
`default_nettype none

package edps_pkg;

  localparam int MAX_QUERY_LEN = 16;
  localparam int QUERY_SLOTS   = 16;
  localparam int CHAR_W        = 8;
  localparam int DIST_W        = 8;
  localparam int SCORE_W       = 9;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int QLEN_W        = 5;

  localparam logic [SCORE_W-1:0] PREFIX_BONUS = 9'd3;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LEN  = 2'd2;

  // token handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [CHAR_W-1:0] ch;
    logic [DIST_W-1:0] left;      // new column value of the sending cell
    logic [DIST_W-1:0] diag;      // old column value of the sending cell
    logic [DIST_W-1:0] distance;  // distance picked up at the query length cell
    logic              pre;       // prefix flag, final on the last character
  } edps_link_t;

  function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] v);
    return (v == DIST_MAX) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/edps_head_cell.sv -----
// head of the cell chain: character position, prefix flag and column entry zero
// depends on edps_pkg
`default_nettype none

module edps_head_cell #(
  parameter int MaxQueryLen = edps_pkg::MAX_QUERY_LEN,
  parameter int LenW        = $clog2(MaxQueryLen + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic                        take,
  input  wire logic [edps_pkg::CHAR_W-1:0] word_char,
  input  wire logic                        last_char,
  input  wire logic [edps_pkg::CHAR_W-1:0] qchars [MaxQueryLen],
  input  wire logic [LenW-1:0]             len,
  output edps_pkg::edps_link_t             link_out
);

  localparam int IdxW = (MaxQueryLen > 1) ? $clog2(MaxQueryLen) : 1;

  logic [edps_pkg::DIST_W-1:0] pos;
  logic                        prefix;
  logic [edps_pkg::DIST_W-1:0] pos_next;
  logic                        prefix_next;
  logic                        in_query;
  logic [edps_pkg::DIST_W-1:0] len_ext;

  assign len_ext  = edps_pkg::DIST_W'(len);
  assign in_query = pos < len_ext;
  assign pos_next = edps_pkg::inc_sat(pos);

  always_comb begin
    prefix_next = prefix;
    if (in_query && (word_char != qchars[pos[IdxW-1:0]])) begin
      prefix_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      prefix         <= 1'b1;
      link_out.valid <= 1'b0;
    end else if (advance) begin
      link_out.valid <= take;
      if (take) begin
        // word state returns to reset after its last character
        pos               <= last_char ? '0 : pos_next;
        prefix            <= last_char ? 1'b1 : prefix_next;
        link_out.last     <= last_char;
        link_out.ch       <= word_char;
        link_out.left     <= pos_next;
        link_out.diag     <= pos;
        link_out.distance <= pos_next;
        link_out.pre      <= prefix_next && (pos_next >= len_ext);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/edps_dp_cell.sv -----
// one column entry of the edit distance recurrence, one query character
// depends on edps_pkg
`default_nettype none

module edps_dp_cell #(
  parameter int MaxQueryLen = edps_pkg::MAX_QUERY_LEN,
  parameter int LenW        = $clog2(MaxQueryLen + 1),
  parameter int Pos         = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic [edps_pkg::CHAR_W-1:0] qchar,
  input  wire logic [LenW-1:0]             len,
  input  wire edps_pkg::edps_link_t        link_in,
  output edps_pkg::edps_link_t             link_out
);

  localparam logic [edps_pkg::DIST_W-1:0] ResetVal = edps_pkg::DIST_W'(Pos);

  logic [edps_pkg::DIST_W-1:0] val;
  logic [edps_pkg::DIST_W-1:0] best;
  logic [edps_pkg::DIST_W-1:0] val_new;

  // min of left, up and diagonal
  always_comb begin
    best = link_in.left;
    if (val < best) begin
      best = val;
    end
    if (link_in.diag < best) begin
      best = link_in.diag;
    end
    val_new = (link_in.ch == qchar) ? link_in.diag : edps_pkg::inc_sat(best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val            <= ResetVal;
      link_out.valid <= 1'b0;
    end else if (advance) begin
      link_out.valid <= link_in.valid;
      if (link_in.valid) begin
        val               <= link_in.last ? ResetVal : val_new;
        link_out.last     <= link_in.last;
        link_out.ch       <= link_in.ch;
        link_out.left     <= val_new;
        link_out.diag     <= val;
        link_out.distance <= (len == LenW'(Pos)) ? val_new : link_in.distance;
        link_out.pre      <= link_in.pre;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/edit_distance_prefix_score_unit.sv -----
// top level: configuration registers, systolic cell chain and result register
// depends on edps_pkg, edps_head_cell and edps_dp_cell
//
// usage: write the query bytes and length through the cfg port while idle,
// then stream word characters on the in channel, last_char set on the final
// character of each word. one result item leaves on the out channel for each
// word when the query length is at least two; otherwise the word is dropped.
// a character enters the chain every cycle and moves one cell per cycle while
// in_stall is low, so a new item is taken each cycle; the result of a word
// passes through the head cell register, the MaxQueryLen column cells and the
// result register, in that order, before it shows on out_valid.
// when the receiver stalls with a result waiting, the chain keeps moving
// until the next result reaches the tail; only then is in_stall raised.
// reset clears the query registers to zero and every cell to its initial
// column value; out_valid drops in the cycle after reset.
`default_nettype none

module edit_distance_prefix_score_unit #(
  parameter int MaxQueryLen = edps_pkg::MAX_QUERY_LEN
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [edps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [edps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [edps_pkg::CHAR_W-1:0]      word_char,
  input  wire logic                             last_char,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [edps_pkg::DIST_W-1:0]           edit_distance,
  output logic                                  is_prefix,
  output logic signed [edps_pkg::SCORE_W-1:0]   score
);

  localparam int LenW = $clog2(MaxQueryLen + 1);

  logic [edps_pkg::CFG_DATA_W-1:0] query_low;
  logic [edps_pkg::CFG_DATA_W-1:0] query_high;
  logic [edps_pkg::QLEN_W-1:0]     query_len;
  logic [LenW-1:0]                 len;
  logic [edps_pkg::CHAR_W-1:0]     qchars [MaxQueryLen];
  logic [2*edps_pkg::CFG_DATA_W-1:0] query_all;

  edps_pkg::edps_link_t link [MaxQueryLen+1];

  logic tail_result;
  logic hold;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_low  <= '0;
      query_high <= '0;
      query_len  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        edps_pkg::REG_QUERY_LOW:  query_low  <= cfg_data;
        edps_pkg::REG_QUERY_HIGH: query_high <= cfg_data;
        edps_pkg::REG_QUERY_LEN:  query_len  <= cfg_data[edps_pkg::QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (query_len > edps_pkg::QLEN_W'(MaxQueryLen)) ? LenW'(MaxQueryLen)
                                                             : LenW'(query_len);
  assign query_all = {query_high, query_low};

  for (genvar i = 0; i < MaxQueryLen; i++) begin : g_qchar
    assign qchars[i] = query_all[i*edps_pkg::CHAR_W +: edps_pkg::CHAR_W];
  end

  // only a result that cannot leave blocks the chain
  assign tail_result = link[MaxQueryLen].valid && link[MaxQueryLen].last && (len >= LenW'(2));
  assign hold        = out_valid && out_stall && tail_result;
  assign advance     = !hold;
  assign in_stall    = hold;

  edps_head_cell #(
    .MaxQueryLen (MaxQueryLen),
    .LenW        (LenW)
  ) u_head (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .take      (in_valid),
    .word_char (word_char),
    .last_char (last_char),
    .qchars    (qchars),
    .len       (len),
    .link_out  (link[0])
  );

  for (genvar k = 1; k <= MaxQueryLen; k++) begin : g_cell
    edps_dp_cell #(
      .MaxQueryLen (MaxQueryLen),
      .LenW        (LenW),
      .Pos         (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .qchar    (qchars[k-1]),
      .len      (len),
      .link_in  (link[k-1]),
      .link_out (link[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= tail_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!(out_valid && out_stall) && tail_result) begin
      edit_distance <= link[MaxQueryLen].distance;
      is_prefix     <= link[MaxQueryLen].pre;
      score         <= link[MaxQueryLen].pre
                       ? ({1'b0, link[MaxQueryLen].distance} - edps_pkg::PREFIX_BONUS)
                       : {1'b0, link[MaxQueryLen].distance};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/edps_checker.sv -----
// port-level checks for the edit distance prefix score unit, bound to the top
// depends on edps_pkg and edit_distance_prefix_score_unit
`default_nettype none

module edps_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_write,
  input wire logic [edps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [edps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [edps_pkg::CHAR_W-1:0]      word_char,
  input wire logic                             last_char,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [edps_pkg::DIST_W-1:0]      edit_distance,
  input wire logic                             is_prefix,
  input wire logic signed [edps_pkg::SCORE_W-1:0] score
);

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edit_distance) && $stable(score))
    else $error("result changed while stalled");

  // score follows distance and prefix flag
  a_score: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_prefix
      ? (score == ({1'b0, edit_distance} - edps_pkg::PREFIX_BONUS))
      : (score == {1'b0, edit_distance})))
    else $error("score does not match distance");

  // input is held back only by a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind edit_distance_prefix_score_unit edps_checker u_edps_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for edit_distance_prefix_score_unit: a directed table, then random query phases
// every word is scored by a local Levenshtein column model and each result item is checked
// depends on edps_pkg and the unit's RTL
module tb_top;

  localparam int SETTLE_CYCLES = edps_pkg::MAX_QUERY_LEN + 8;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 200;
  localparam int LONG_WORD     = 300;
  localparam int PHASES        = 10;
  localparam logic [edps_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [edps_pkg::CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [edps_pkg::DIST_W-1:0]  distance;
    logic                         pre;
    logic [edps_pkg::SCORE_W-1:0] score;
  } score_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } word_item_t;

  typedef enum logic {ROW_CHAR, ROW_SETUP} row_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    logic [edps_pkg::CFG_INDEX_W-1:0]     idx;
    logic [edps_pkg::CFG_DATA_W-1:0]      data;
    char_t                                ch;
    logic                                 last;
    logic                                 typed;
    score_t                               want;
  } stim_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [edps_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [edps_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  char_t                               word_char = '0;
  logic                                last_char = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [edps_pkg::DIST_W-1:0]         edit_distance;
  logic                                is_prefix;
  logic signed [edps_pkg::SCORE_W-1:0] score;

  edit_distance_prefix_score_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .word_char    (word_char),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edit_distance(edit_distance),
    .is_prefix    (is_prefix),
    .score        (score)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the query registers and the word state
  logic [edps_pkg::CFG_DATA_W-1:0] query_low = '0;
  logic [edps_pkg::CFG_DATA_W-1:0] query_high = '0;
  logic [edps_pkg::QLEN_W-1:0]     query_len = '0;
  logic [edps_pkg::DIST_W-1:0]     dist_column [0:edps_pkg::MAX_QUERY_LEN];
  logic [edps_pkg::DIST_W-1:0]     chars_seen;
  logic                            still_prefix;

  score_t     pending_scores [$];
  stim_row_t  directed_rows [$];
  word_item_t char_stream [$];
  char_t      alphabet [4];
  idle_mode_t idle_mode = IDLE_NONE;
  int         hold_request = 0;

  int errors = 0;
  int chars_sent = 0;
  int reg_writes = 0;
  int scores_checked = 0;
  int prefix_hits = 0;
  int saturated_hits = 0;

  function automatic char_t query_byte(input int k);
    return (k < 8) ? query_low[8*k +: 8] : query_high[8*(k-8) +: 8];
  endfunction

  function automatic int active_len();
    return (query_len > edps_pkg::MAX_QUERY_LEN) ? edps_pkg::MAX_QUERY_LEN : int'(query_len);
  endfunction

  function automatic logic [edps_pkg::DIST_W-1:0] sat_incr(
      input logic [edps_pkg::DIST_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void restart_word();
    for (int k = 0; k <= edps_pkg::MAX_QUERY_LEN; k++) dist_column[k] = edps_pkg::DIST_W'(k);
    chars_seen = '0;
    still_prefix = 1'b1;
  endfunction

  function automatic void apply_reg(input logic [edps_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [edps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      edps_pkg::REG_QUERY_LOW:  query_low = data;
      edps_pkg::REG_QUERY_HIGH: query_high = data;
      edps_pkg::REG_QUERY_LEN:  query_len = data[edps_pkg::QLEN_W-1:0];
      default: ;
    endcase
  endfunction

  // one column update over all query slots; returns 1 when the word yields a score
  function automatic logic score_char(input char_t ch, input logic last, output score_t res);
    int                          len;
    logic                        found;
    logic [edps_pkg::DIST_W-1:0] diag, up, best, next_pos;
    len = active_len();
    found = 1'b0;
    res = '0;
    if (chars_seen < len && ch != query_byte(chars_seen)) still_prefix = 1'b0;
    next_pos = sat_incr(chars_seen);
    diag = dist_column[0];
    dist_column[0] = next_pos;
    for (int k = 1; k <= edps_pkg::MAX_QUERY_LEN; k++) begin
      up = dist_column[k];
      if (query_byte(k - 1) == ch) begin
        dist_column[k] = diag;
      end else begin
        best = dist_column[k - 1];
        if (up < best) best = up;
        if (diag < best) best = diag;
        dist_column[k] = sat_incr(best);
      end
      diag = up;
    end
    chars_seen = next_pos;
    if (last) begin
      if (len >= 2) begin
        res.distance = dist_column[len];
        res.pre = still_prefix && (chars_seen >= len);
        res.score = res.pre ? {1'b0, res.distance} - edps_pkg::PREFIX_BONUS
                            : {1'b0, res.distance};
        found = 1'b1;
      end
      restart_word();
    end
    return found;
  endfunction

  function automatic char_t pick_char();
    return ($urandom_range(99) < 85) ? alphabet[$urandom_range(3)]
                                     : edps_pkg::CHAR_W'($urandom);
  endfunction

  function automatic int sender_gap();
    int gap = 0;
    if (idle_mode == IDLE_SENDER) begin
      while ($urandom_range(99) < 75) gap++;
    end else if (idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < 13) gap++;
    end
    return gap;
  endfunction

  function automatic void add_char(input char_t ch, input logic last);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CHAR;
    row.ch = ch;
    row.last = last;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_word(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endfunction

  function automatic void add_setup(input logic [edps_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [edps_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SETUP;
    row.idx = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void mark_expected(input logic [edps_pkg::DIST_W-1:0] distance,
                                        input logic pre,
                                        input logic [edps_pkg::SCORE_W-1:0] sc);
    int r;
    r = directed_rows.size() - 1;
    directed_rows[r].typed = 1'b1;
    directed_rows[r].want = '{distance: distance, pre: pre, score: sc};
  endfunction

  // drop valid, let every pending score come out, then let the chain settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [edps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [edps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_char(input char_t ch, input logic last, input logic typed,
                           input score_t want);
    int     gap;
    score_t pred;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      word_char <= edps_pkg::CHAR_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    word_char <= ch;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    if (score_char(ch, last, pred)) pending_scores.push_back(typed ? want : pred);
  endtask

  // mostly edited copies of the query, some random words and some raw bytes
  task automatic gen_word();
    char_t w [$];
    int    style, n, pos;
    style = $urandom_range(99);
    if (style < 55) begin
      n = $urandom_range(active_len() + 2);
      for (int i = 0; i < n; i++)
        w.push_back(i < edps_pkg::MAX_QUERY_LEN ? query_byte(i) : pick_char());
      repeat ($urandom_range(2)) begin
        pos = $urandom_range(w.size());
        case ($urandom_range(2))
          0: w.insert(pos, pick_char());
          1: if (pos < w.size()) w.delete(pos);
          default: if (pos < w.size()) w[pos] = pick_char();
        endcase
      end
      repeat ($urandom_range(3)) w.push_back(pick_char());
    end else if (style < 85) begin
      repeat ($urandom_range(20, 1)) w.push_back(pick_char());
    end else begin
      repeat ($urandom_range(12, 1)) w.push_back(edps_pkg::CHAR_W'($urandom));
    end
    if (w.size() == 0) w.push_back(pick_char());
    foreach (w[i]) char_stream.push_back('{ch: w[i], last: i == w.size() - 1});
  endtask

  // long enough that the position count and the distance both saturate
  task automatic gen_long_word(input logic with_prefix);
    char_t ch;
    for (int i = 0; i < LONG_WORD; i++) begin
      ch = (with_prefix && i < edps_pkg::MAX_QUERY_LEN) ? query_byte(i) : pick_char();
      char_stream.push_back('{ch: ch, last: i == LONG_WORD - 1});
    end
  endtask

  task automatic program_query(input int len_value, input logic all_regs);
    logic [edps_pkg::CFG_DATA_W-1:0] lo, hi, len_word;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_char();
      hi[8*i +: 8] = pick_char();
    end
    len_word = {$urandom, $urandom};
    len_word[edps_pkg::QLEN_W-1:0] = edps_pkg::QLEN_W'(len_value);
    if (all_regs || $urandom_range(3) != 0) write_reg(edps_pkg::REG_QUERY_LOW, lo);
    if (all_regs || $urandom_range(3) != 0) write_reg(edps_pkg::REG_QUERY_HIGH, hi);
    if ($urandom_range(4) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(edps_pkg::REG_QUERY_LEN, len_word);
  endtask

  initial begin : stimulus
    int len_value;
    int budget;
    restart_word();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);            // query length still zero from reset, no score
    add_setup(edps_pkg::REG_QUERY_HIGH, '1);
    add_setup(edps_pkg::REG_QUERY_LOW, 64'h6261);
    add_setup(edps_pkg::REG_QUERY_LEN, 64'd2);
    add_word("ab");
    mark_expected(8'd0, 1'b1, -9'sd3);
    add_word("abc");
    mark_expected(8'd1, 1'b1, -9'sd2);
    add_word("x");
    mark_expected(8'd2, 1'b0, 9'sd2);
    add_word("a");                    // word shorter than the query is not prefixed
    mark_expected(8'd1, 1'b0, 9'sd1);
    add_setup(edps_pkg::REG_QUERY_LEN, 64'd1);
    add_word("a");                    // one-character query gives no score
    add_setup(edps_pkg::REG_QUERY_LOW, '0);
    add_setup(edps_pkg::REG_QUERY_LEN, '1);     // 31 is taken as the full sixteen
    add_char(8'h00, 1'b1);
    mark_expected(8'd15, 1'b0, 9'sd15);
    add_setup(REG_SPARE, '1);
    add_setup(edps_pkg::REG_QUERY_LOW, 64'h636261);
    add_setup(edps_pkg::REG_QUERY_LEN, 64'd2);
    add_char(8'h61, 1'b0);
    add_setup(edps_pkg::REG_QUERY_LEN, 64'd3);  // length grows in mid-word
    add_word("bc");

    idle_mode = IDLE_BOTH;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SETUP) begin
        wait_idle();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_char(directed_rows[r].ch, directed_rows[r].last, directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      foreach (alphabet[a]) alphabet[a] = edps_pkg::CHAR_W'($urandom);
      case (phase)
        0: len_value = 2;
        1: len_value = edps_pkg::MAX_QUERY_LEN;
        2: len_value = 0;
        3: len_value = 31;
        5: len_value = 1;
        6: len_value = $urandom_range(31, edps_pkg::MAX_QUERY_LEN + 1);
        default: len_value = $urandom_range(edps_pkg::MAX_QUERY_LEN, 2);
      endcase
      wait_idle();
      idle_mode = idle_mode_t'(phase % 4);
      program_query(len_value, phase == 0);
      budget = (len_value < 2) ? 40 : 165;
      char_stream.delete();
      if (phase == 1) begin
        gen_long_word(1'b1);
        gen_long_word(1'b0);
        budget += 2 * LONG_WORD;
      end
      while (char_stream.size() < budget) gen_word();
      // sender keeps offering while the receiver holds off
      if (phase == 4) hold_request = HOLD_CYCLES;
      // the stream may stop in mid-word, carried over into the next setting
      for (int i = 0; i < budget; i++)
        send_char(char_stream[i].ch, char_stream[i].last, 1'b0, '0);
    end

    wait_idle();
    $display("%0d characters sent, %0d register writes", chars_sent, reg_writes);
    $display("%0d scores checked, %0d with the query as prefix, %0d saturated",
             scores_checked, prefix_hits, saturated_hits);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : receiver
    int held;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (held) @(negedge clk);
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 75);
          IDLE_BOTH:     out_stall <= ($urandom_range(99) < 13);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_scores
    score_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("result item with no word pending: edit_distance %0d", edit_distance);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        scores_checked++;
        if (want.pre) prefix_hits++;
        if (want.distance == edps_pkg::DIST_MAX) saturated_hits++;
        if (edit_distance !== want.distance) begin
          $error("edit_distance expected %0d got %0d", want.distance, edit_distance);
          errors++;
        end
        if (is_prefix !== want.pre) begin
          $error("is_prefix expected %0d got %0d", want.pre, is_prefix);
          errors++;
        end
        if (score !== want.score) begin
          $error("score expected %0d got %0d", $signed(want.score), score);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck = 0;
      else
        stuck++;
    end
    $error("no item moved for %0d cycles", STUCK_LIMIT);
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- edit_distance_prefix_score_unit.f -----
rtl/core/edps_pkg.sv
rtl/core/edps_head_cell.sv
rtl/core/edps_dp_cell.sv
rtl/core/edit_distance_prefix_score_unit.sv
rtl/core/edps_checker.sv
test/tb_top.sv
